// File: design/mexp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mexp_pkg;

  localparam int unsigned WIDTH = 32;
  localparam int unsigned CNT_W = $clog2(WIDTH);

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_STEP,
    OP_RED_WB,
    OP_ACC_INIT,
    OP_ACC_WB,
    OP_SQ_INIT,
    OP_SQ_WB,
    OP_OUT_ACC,
    OP_OUT_BAD,
    OP_OUT_ONE
  } op_e;

  typedef struct packed {
    logic m_zero;
    logic e_zero;
    logic e_lsb;
    logic e_rest_zero;
    logic step_last;
  } status_t;

endpackage

`default_nettype wire

// File: design/mexp_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module mexp_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire mexp_pkg::status_t status_i,
  output mexp_pkg::op_e          op_o,
  output logic                   busy_o,
  output logic                   done_o
);
  import mexp_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_REDUCE,
    S_RED_WB,
    S_TEST,
    S_MUL_ACC,
    S_ACC_WB,
    S_SHIFT,
    S_MUL_SQ,
    S_SQ_WB
  } state_e;

  state_e state_q, state_d;
  logic   done_q, done_d;
  op_e    op;

  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    op      = OP_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          op      = OP_LOAD;
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status_i.m_zero) begin
          op      = OP_OUT_BAD;
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else if (status_i.e_zero) begin
          op      = OP_OUT_ONE;
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          state_d = S_REDUCE;
        end
      end
      S_REDUCE: begin
        op = OP_STEP;
        if (status_i.step_last) state_d = S_RED_WB;
      end
      S_RED_WB: begin
        op      = OP_RED_WB;
        state_d = S_TEST;
      end
      S_TEST: begin
        if (status_i.e_lsb) begin
          op      = OP_ACC_INIT;
          state_d = S_MUL_ACC;
        end else begin
          state_d = S_SHIFT;
        end
      end
      S_MUL_ACC: begin
        op = OP_STEP;
        if (status_i.step_last) state_d = S_ACC_WB;
      end
      S_ACC_WB: begin
        op      = OP_ACC_WB;
        state_d = S_SHIFT;
      end
      S_SHIFT: begin
        if (status_i.e_rest_zero) begin
          op      = OP_OUT_ACC;
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          op      = OP_SQ_INIT;
          state_d = S_MUL_SQ;
        end
      end
      S_MUL_SQ: begin
        op = OP_STEP;
        if (status_i.step_last) state_d = S_SQ_WB;
      end
      S_SQ_WB: begin
        op      = OP_SQ_WB;
        state_d = S_TEST;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  assign op_o   = op;
  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;

endmodule

`default_nettype wire

// File: design/mexp_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module mexp_dp (
  input  wire logic                        clk_i,
  input  wire logic [mexp_pkg::WIDTH-1:0]  base_i,
  input  wire logic [mexp_pkg::WIDTH-1:0]  exponent_i,
  input  wire logic [mexp_pkg::WIDTH-1:0]  modulus_i,
  input  wire mexp_pkg::op_e               op_i,
  output mexp_pkg::status_t                status_o,
  output logic      [mexp_pkg::WIDTH-1:0]  power_mod_o,
  output logic                             bad_modulus_o
);
  import mexp_pkg::*;

  logic [WIDTH-1:0] m_q, e_q, sq_q, acc_q, r_q, a_q, b_q, res_q;
  logic [WIDTH-1:0] m_d, e_d, sq_d, acc_d, r_d, a_d, b_d, res_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             red_q, red_d, bad_q, bad_d;

  logic [WIDTH+1:0] addend, t, t_m, t_2m, m_ext, m2_ext;
  logic [WIDTH-1:0] r_next;

  // one interleaved step: r = (2r + addend) mod m, addend at most m
  always_comb begin
    m_ext  = {2'b00, m_q};
    m2_ext = {1'b0, m_q, 1'b0};
    if (red_q) addend = {{(WIDTH+1){1'b0}}, b_q[WIDTH-1]};
    else if (b_q[WIDTH-1]) addend = {2'b00, a_q};
    else addend = '0;
    t    = {1'b0, r_q, 1'b0} + addend;
    t_m  = t - m_ext;
    t_2m = t - m2_ext;
    if (t >= m2_ext) r_next = t_2m[WIDTH-1:0];
    else if (t >= m_ext) r_next = t_m[WIDTH-1:0];
    else r_next = t[WIDTH-1:0];
  end

  always_comb begin
    m_d   = m_q;
    e_d   = e_q;
    sq_d  = sq_q;
    acc_d = acc_q;
    r_d   = r_q;
    a_d   = a_q;
    b_d   = b_q;
    res_d = res_q;
    cnt_d = cnt_q;
    red_d = red_q;
    bad_d = bad_q;
    case (op_i)
      OP_LOAD: begin
        m_d   = modulus_i;
        e_d   = exponent_i;
        b_d   = base_i;
        r_d   = '0;
        cnt_d = '0;
        red_d = 1'b1;
      end
      OP_STEP: begin
        r_d   = r_next;
        b_d   = {b_q[WIDTH-2:0], 1'b0};
        cnt_d = cnt_q + 1'b1;
      end
      OP_RED_WB: begin
        sq_d  = r_q;
        acc_d = (m_q == WIDTH'(1)) ? '0 : WIDTH'(1);
      end
      OP_ACC_INIT: begin
        a_d   = acc_q;
        b_d   = sq_q;
        r_d   = '0;
        cnt_d = '0;
        red_d = 1'b0;
      end
      OP_ACC_WB: acc_d = r_q;
      OP_SQ_INIT: begin
        e_d   = {1'b0, e_q[WIDTH-1:1]};
        a_d   = sq_q;
        b_d   = sq_q;
        r_d   = '0;
        cnt_d = '0;
        red_d = 1'b0;
      end
      OP_SQ_WB: begin
        sq_d = r_q;
        // the test state looks at the next exponent bit
      end
      OP_OUT_ACC: begin
        res_d = acc_q;
        bad_d = 1'b0;
      end
      OP_OUT_BAD: begin
        res_d = '0;
        bad_d = 1'b1;
      end
      OP_OUT_ONE: begin
        res_d = WIDTH'(1);
        bad_d = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    m_q   <= m_d;
    e_q   <= e_d;
    sq_q  <= sq_d;
    acc_q <= acc_d;
    r_q   <= r_d;
    a_q   <= a_d;
    b_q   <= b_d;
    res_q <= res_d;
    cnt_q <= cnt_d;
    red_q <= red_d;
    bad_q <= bad_d;
  end

  assign status_o.m_zero      = (m_q == '0);
  assign status_o.e_zero      = (e_q == '0);
  assign status_o.e_lsb       = e_q[0];
  assign status_o.e_rest_zero = (e_q[WIDTH-1:1] == '0);
  assign status_o.step_last   = (cnt_q == CNT_W'(WIDTH-1));

  assign power_mod_o   = res_q;
  assign bad_modulus_o = bad_q;

endmodule

`default_nettype wire

// File: design/modular_exponentiation.sv
// channel   signals                                    transaction
// command   start_i, busy_o, base_i, exponent_i,       start_i & !busy_o
//           modulus_i
// result    done_o, power_mod_o, bad_modulus_o         done_o, one cycle
//
// one transaction at a time; a shared interleaved modular multiplier does one
// bit per cycle; a zero modulus or zero exponent finishes without the multiplier
// reset is asynchronous, active low; it clears the controller only
// the receiver cannot stall; a new start may be taken while done_o is high
`timescale 1ns / 1ps
`default_nettype none

module modular_exponentiation (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [mexp_pkg::WIDTH-1:0]  base_i,
  input  wire logic [mexp_pkg::WIDTH-1:0]  exponent_i,
  input  wire logic [mexp_pkg::WIDTH-1:0]  modulus_i,
  output logic                             busy_o,
  output logic                             done_o,
  output logic      [mexp_pkg::WIDTH-1:0]  power_mod_o,
  output logic                             bad_modulus_o
);
  import mexp_pkg::*;

  op_e     op;
  status_t status;

  mexp_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .status_i (status),
    .op_o     (op),
    .busy_o   (busy_o),
    .done_o   (done_o)
  );

  mexp_dp u_dp (
    .clk_i         (clk_i),
    .base_i        (base_i),
    .exponent_i    (exponent_i),
    .modulus_i     (modulus_i),
    .op_i          (op),
    .status_o      (status),
    .power_mod_o   (power_mod_o),
    .bad_modulus_o (bad_modulus_o)
  );

endmodule

`default_nettype wire

// File: design/mexp_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module mexp_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        start_i,
  input wire logic                        busy_i,
  input wire logic                        done_i,
  input wire logic [mexp_pkg::WIDTH-1:0]  power_mod_i,
  input wire logic                        bad_modulus_i
);
  import mexp_pkg::*;

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_i |=> busy_i)
    else $error("accepted command did not raise busy");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_i |=> !done_i)
    else $error("done held longer than one cycle");

  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_i && bad_modulus_i |-> power_mod_i == '0)
    else $error("bad modulus with nonzero result");

  a_fall_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_i) |-> done_i)
    else $error("busy dropped without a result");

  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_i |-> $past(busy_i))
    else $error("result without a command in flight");

endmodule

bind modular_exponentiation mexp_checker u_mexp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start_i       (start_i),
  .busy_i        (busy_o),
  .done_i        (done_o),
  .power_mod_i   (power_mod_o),
  .bad_modulus_i (bad_modulus_o)
);

`default_nettype wire
